// ----- design/agga_pkg.sv -----
package agga_pkg;
   localparam int MaxLen = 256;
   localparam int LenW = $clog2(MaxLen + 1);
   localparam int IdxW = $clog2(MaxLen);
   localparam int ScoreW = 24;
   localparam int PtrDepth = (MaxLen + 1) * (MaxLen + 1);
   localparam int PtrW = $clog2(PtrDepth);
   localparam logic [7:0] GapChar = 8'd45;
   localparam logic signed [ScoreW-1:0] ScoreHi = {1'b0, {(ScoreW-1){1'b1}}};
   localparam logic signed [ScoreW-1:0] ScoreLo = {1'b1, {(ScoreW-1){1'b0}}};

   typedef enum logic [2:0] {
      REQ_CLEAR = 3'd0, REQ_SRC = 3'd1, REQ_TXT = 3'd2, REQ_COMPUTE = 3'd3, REQ_NEXT = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_NONLETTER = 3'd2, ST_NOT_COMPUTED = 3'd3,
      ST_FINISHED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      DIR_LEFT = 2'd0, DIR_UP = 2'd1, DIR_DIAG = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      CSR_OPEN = 2'd0, CSR_EXTEND = 2'd1, CSR_MATCH = 2'd2, CSR_MISMATCH = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_EDGE, S_ROW, S_RD, S_CELL, S_WB, S_DONE, S_TRD, S_TDIR, S_TSYM, S_RESP
   } state_type;

   // cell operands and results between sequencer and cell unit
   typedef struct packed {
      logic signed [ScoreW-1:0] diag;
      logic signed [ScoreW-1:0] up;
      logic signed [ScoreW-1:0] vgap;
      logic signed [ScoreW-1:0] left;
      logic signed [ScoreW-1:0] hgap;
      logic                     equal;
   } cell_in_type;

   typedef struct packed {
      logic signed [ScoreW-1:0] best;
      logic signed [ScoreW-1:0] vgap;
      logic signed [ScoreW-1:0] hgap;
      dir_type                  dir;
   } cell_out_type;

   function automatic logic signed [ScoreW-1:0] sat_add(input logic signed [ScoreW+1:0] v);
      if (v > ScoreW'(ScoreHi) && v > $signed({3'b000, ScoreHi[ScoreW-2:0]}))
         return ScoreHi;
      if (v < $signed({{3{1'b1}}, ScoreLo[ScoreW-2:0]}))
         return ScoreLo;
      return v[ScoreW-1:0];
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return (l >= 8'h61) && (l <= 8'h7a);
   endfunction
endpackage

// ----- design/affine_gap_global_alignment_unit.sv -----
// channel  | direction | ports
// req      | in        | req_valid req_ready req_type req_symbol
// rsp      | out       | rsp_valid rsp_ready rsp_status rsp_score rsp_source_symbol
//          |           | rsp_text_symbol rsp_match_mark rsp_last_column
// csr      | in        | csr_valid csr_ready csr_index csr_data
// clear and status-only words go straight to S_RESP; appends pass S_WB, traced columns
// S_TRD, S_TDIR and S_TSYM; compute fills row 0 in S_EDGE, then each row in S_ROW, S_RD
// and S_CELL/S_TSYM per cell, on the single shared cell unit and registered row memory reads
// reset is synchronous; pointer and row memories need no clearing
// req_ready is low from acceptance until the response word is taken
module affine_gap_global_alignment_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic signed [23:0] rsp_score,
   output logic [7:0]  rsp_source_symbol,
   output logic [7:0]  rsp_text_symbol,
   output logic        rsp_match_mark,
   output logic        rsp_last_column,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);
   import agga_pkg::*;

   localparam logic signed [ScoreW-1:0] NegInf = -ScoreW'(4000000);

   state_type state_ff, state_in;
   logic [9:0] open_ff, ext_ff;
   logic signed [9:0] match_ff, mism_ff;
   logic [LenW-1:0] slen_ff, tlen_ff, i_ff, j_ff, i_in, j_in;
   logic [LenW-1:0] tr_ff, tc_ff, tr_in, tc_in;
   logic computed_ff, computed_in;
   logic signed [ScoreW-1:0] final_ff, final_in;
   logic signed [ScoreW-1:0] diag_ff, left_ff, hgap_ff, edge_ff;
   logic signed [ScoreW-1:0] diag_in, left_in, hgap_in, edge_in;
   logic [2:0] req_ff;
   logic [7:0] sym_ff;
   logic [2:0] st_ff, st_in;
   logic [7:0] ss_ff, ts_ff, ss_in, ts_in;
   dir_type dir_ff, dir_in;

   logic [7:0] src_mem [MaxLen];
   logic [7:0] txt_mem [MaxLen];
   logic signed [ScoreW-1:0] best_mem [MaxLen+1];
   logic signed [ScoreW-1:0] vgap_mem [MaxLen+1];
   logic [1:0] ptr_mem [PtrDepth];

   logic [7:0] src_rd, txt_rd;
   logic signed [ScoreW-1:0] best_rd, vgap_rd;
   logic [1:0] ptr_rd;
   logic [IdxW-1:0] src_ra, txt_ra;
   logic [LenW-1:0] row_ra, row_wa;
   logic [PtrW-1:0] ptr_ra, ptr_wa;
   logic row_we, ptr_we, src_we, txt_we;
   logic signed [ScoreW-1:0] best_wd, vgap_wd;
   cell_in_type cin;
   cell_out_type cout;
   logic cell_en;

   always_ff @(posedge clock) begin
      src_rd <= src_mem[src_ra];
      txt_rd <= txt_mem[txt_ra];
      best_rd <= best_mem[row_ra];
      vgap_rd <= vgap_mem[row_ra];
      ptr_rd <= ptr_mem[ptr_ra];
      if (src_we) src_mem[slen_ff[IdxW-1:0]] <= sym_ff;
      if (txt_we) txt_mem[tlen_ff[IdxW-1:0]] <= sym_ff;
      if (row_we) begin
         best_mem[row_wa] <= best_wd;
         vgap_mem[row_wa] <= vgap_wd;
      end
      if (ptr_we) ptr_mem[ptr_wa] <= cout.dir;
   end

   agga_cell u_cell (
      .clock(clock), .en(cell_en), .gap_open(open_ff), .gap_extend(ext_ff),
      .match_score(match_ff), .mismatch_score(mism_ff), .cin(cin), .cout(cout)
   );

   assign cin = '{diag: diag_ff, up: best_rd, vgap: vgap_rd, left: left_ff, hgap: hgap_ff,
                  equal: (src_rd & 8'hdf) == (txt_rd & 8'hdf)};

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0; ext_ff <= '0; match_ff <= 10'sd20; mism_ff <= -10'sd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OPEN:     open_ff <= csr_data;
            CSR_EXTEND:   ext_ff <= csr_data;
            CSR_MATCH:    match_ff <= $signed(csr_data);
            CSR_MISMATCH: mism_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   logic signed [ScoreW+1:0] edge_next;
   assign edge_next = (ScoreW+2)'(edge_ff) - $signed({{(ScoreW-8){1'b0}}, ext_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slen_ff <= '0; tlen_ff <= '0; computed_ff <= 1'b0; final_ff <= '0;
         tr_ff <= '0; tc_ff <= '0;
      end else begin
         state_ff <= state_in;
         computed_ff <= computed_in; final_ff <= final_in;
         tr_ff <= tr_in; tc_ff <= tc_in;
         if (src_we) slen_ff <= slen_ff + 1'b1;
         if (txt_we) tlen_ff <= tlen_ff + 1'b1;
         if (state_ff == S_IDLE && req_valid && req_type == REQ_CLEAR) begin
            slen_ff <= '0; tlen_ff <= '0;
         end
      end
      i_ff <= i_in; j_ff <= j_in;
      diag_ff <= diag_in; left_ff <= left_in; hgap_ff <= hgap_in; edge_ff <= edge_in;
      st_ff <= st_in; ss_ff <= ss_in; ts_ff <= ts_in; dir_ff <= dir_in;
      if (state_ff == S_IDLE) begin
         req_ff <= req_type; sym_ff <= req_symbol;
      end
   end

   always_comb begin
      state_in = state_ff;
      computed_in = computed_ff; final_in = final_ff; tr_in = tr_ff; tc_in = tc_ff;
      i_in = i_ff; j_in = j_ff;
      diag_in = diag_ff; left_in = left_ff; hgap_in = hgap_ff; edge_in = edge_ff;
      st_in = st_ff; ss_in = ss_ff; ts_in = ts_ff; dir_in = dir_ff;
      src_we = 1'b0; txt_we = 1'b0; row_we = 1'b0; ptr_we = 1'b0; cell_en = 1'b0;
      src_ra = j_ff[IdxW-1:0]; txt_ra = j_ff[IdxW-1:0];
      row_ra = j_ff; row_wa = j_ff;
      best_wd = cout.best; vgap_wd = cout.vgap;
      ptr_wa = PtrW'(i_ff * (MaxLen + 1) + j_ff);
      ptr_ra = PtrW'(tr_ff * (MaxLen + 1) + tc_ff);
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            st_in = ST_OK; ss_in = '0; ts_in = '0;
            unique case (req_type) inside
               REQ_CLEAR: begin
                  computed_in = 1'b0; final_in = '0; tr_in = '0; tc_in = '0;
                  state_in = S_RESP;
               end
               REQ_SRC, REQ_TXT: begin
                  if (!is_letter(req_symbol)) st_in = ST_NONLETTER;
                  else if ((req_type == REQ_SRC ? slen_ff : tlen_ff) >= LenW'(MaxLen))
                     st_in = ST_FULL;
                  else computed_in = 1'b0;
                  state_in = S_WB;
               end
               REQ_COMPUTE: begin
                  // row 0: best = edge, vgap = -inf
                  j_in = '0; edge_in = -$signed({{(ScoreW-10){1'b0}}, open_ff});
                  state_in = S_EDGE;
               end
               REQ_NEXT: begin
                  if (!computed_ff) begin st_in = ST_NOT_COMPUTED; state_in = S_RESP; end
                  else if (tr_ff == '0 && tc_ff == '0) begin
                     st_in = ST_FINISHED; state_in = S_RESP;
                  end else state_in = S_TRD;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_WB: begin
            // store the word if accepted
            if (st_ff == ST_OK) begin
               if (req_ff == REQ_SRC) src_we = 1'b1; else txt_we = 1'b1;
            end
            state_in = S_RESP;
         end
         S_EDGE: begin
            row_we = 1'b1; row_wa = j_ff; vgap_wd = NegInf;
            best_wd = (j_ff == '0) ? '0 : sat_add(edge_next);
            if (j_ff != '0) edge_in = sat_add(edge_next);
            if (j_ff == tlen_ff) begin
               i_in = '0; edge_in = -$signed({{(ScoreW-10){1'b0}}, open_ff});
               state_in = S_ROW;
            end else j_in = j_ff + 1'b1;
         end
         S_ROW: begin
            if (i_ff == slen_ff) state_in = S_DONE;
            else begin
               i_in = i_ff + 1'b1; j_in = '0; row_ra = '0;
               edge_in = sat_add(edge_next);
               state_in = S_RD;
            end
            row_ra = '0;
         end
         S_RD: begin
            // j_ff points at previous column; fetch column j_ff+1
            if (j_ff == '0) begin
               diag_in = best_rd; left_in = edge_ff; hgap_in = NegInf;
               row_we = 1'b1; row_wa = '0; best_wd = edge_ff; vgap_wd = vgap_rd;
            end
            if (j_ff == tlen_ff) state_in = S_ROW;
            else begin
               row_ra = j_ff + 1'b1;
               src_ra = IdxW'(i_ff - 1'b1); txt_ra = j_ff[IdxW-1:0];
               j_in = j_ff + 1'b1;
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            cell_en = 1'b1;
            diag_in = best_rd;
            state_in = S_TSYM;
         end
         S_TSYM: begin
            if (req_ff == REQ_COMPUTE) begin
               row_we = 1'b1; ptr_we = 1'b1;
               left_in = cout.best; hgap_in = cout.hgap;
               if (j_ff == tlen_ff) state_in = S_ROW;
               else begin
                  row_ra = j_ff + 1'b1;
                  src_ra = IdxW'(i_ff - 1'b1); txt_ra = j_ff[IdxW-1:0];
                  j_in = j_ff + 1'b1;
                  state_in = S_CELL;
               end
            end else begin
               // trace: src_rd/txt_rd ready
               if (dir_ff == DIR_DIAG) begin
                  ss_in = src_rd; ts_in = txt_rd; tr_in = tr_ff - 1'b1; tc_in = tc_ff - 1'b1;
               end else if (dir_ff == DIR_UP) begin
                  ss_in = src_rd; ts_in = GapChar; tr_in = tr_ff - 1'b1;
               end else begin
                  ss_in = GapChar; ts_in = txt_rd; tc_in = tc_ff - 1'b1;
               end
               state_in = S_RESP;
            end
         end
         S_DONE: begin
            // fetch entry tlen of the last row as the final score
            row_ra = tlen_ff;
            state_in = S_TDIR;
         end
         S_TRD: begin
            src_ra = IdxW'(tr_ff - 1'b1); txt_ra = IdxW'(tc_ff - 1'b1);
            state_in = S_TDIR;
         end
         S_TDIR: begin
            if (req_ff == REQ_COMPUTE) begin
               final_in = best_rd; tr_in = slen_ff; tc_in = tlen_ff; computed_in = 1'b1;
               state_in = S_RESP;
            end else begin
               if (tr_ff == '0) dir_in = DIR_LEFT;
               else if (tc_ff == '0) dir_in = DIR_UP;
               else dir_in = dir_type'(ptr_rd);
               src_ra = IdxW'(tr_ff - 1'b1); txt_ra = IdxW'(tc_ff - 1'b1);
               state_in = S_TSYM;
            end
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_status = st_ff;
   assign rsp_score = computed_ff ? final_ff : '0;
   assign rsp_source_symbol = ss_ff;
   assign rsp_text_symbol = ts_ff;
   assign rsp_match_mark = (st_ff == ST_OK && req_ff == REQ_NEXT) ? (ss_ff == ts_ff) : 1'b0;
   assign rsp_last_column = (st_ff == ST_OK && req_ff == REQ_NEXT) ?
                            (tr_ff == '0 && tc_ff == '0) : 1'b0;
endmodule

// ----- design/agga_cell.sv -----
module agga_cell (
   input  logic                 clock,
   input  logic                 en,
   input  logic [9:0]           gap_open,
   input  logic [9:0]           gap_extend,
   input  logic signed [9:0]    match_score,
   input  logic signed [9:0]    mismatch_score,
   input  agga_pkg::cell_in_type  cin,
   output agga_pkg::cell_out_type cout
);
   import agga_pkg::*;

   logic signed [ScoreW+1:0] ex, oe;
   logic signed [ScoreW-1:0] g, fu, fv, f, eu, ev, e, v;
   dir_type d;
   cell_out_type cout_ff;

   always_comb begin
      ex = $signed({{(ScoreW-8){1'b0}}, gap_extend});
      oe = $signed({{(ScoreW-8){1'b0}}, gap_open}) + ex;
      g  = sat_add((ScoreW+2)'(cin.diag) +
                   (ScoreW+2)'(cin.equal ? match_score : mismatch_score));
      fu = sat_add((ScoreW+2)'(cin.vgap) - ex);
      fv = sat_add((ScoreW+2)'(cin.up) - oe);
      f  = (fu > fv) ? fu : fv;
      eu = sat_add((ScoreW+2)'(cin.hgap) - ex);
      ev = sat_add((ScoreW+2)'(cin.left) - oe);
      e  = (eu > ev) ? eu : ev;
      if (g >= f) v = (g >= e) ? g : e;
      else v = (f >= e) ? f : e;
      if (v == f) d = DIR_UP;
      else if (v == e) d = DIR_LEFT;
      else d = DIR_DIAG;
   end

   always_ff @(posedge clock) begin
      if (en) cout_ff <= '{best: v, vgap: f, hgap: e, dir: d};
   end

   assign cout = cout_ff;
endmodule

// ----- design/agga_checker.sv -----
module agga_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic signed [23:0] rsp_score,
   input logic rsp_last_column,
   input logic rsp_match_mark
);
   import agga_pkg::*;

   // one word at a time
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready while response pending");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after an accepted word");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_last_column || rsp_match_mark) |-> rsp_status == ST_OK)
      else $error("column flags with bad status");
   a_nc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_COMPUTED |-> rsp_score == '0)
      else $error("score without compute");
endmodule

bind affine_gap_global_alignment_unit agga_checker u_agga_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_score(rsp_score), .rsp_last_column(rsp_last_column),
   .rsp_match_mark(rsp_match_mark)
);

// ----- test/affine_gap_global_alignment_unit_checker.sv -----
module affine_gap_global_alignment_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic [7:0]         req_symbol,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic signed [23:0] rsp_score,
   input  logic [7:0]         rsp_source_symbol,
   input  logic [7:0]         rsp_text_symbol,
   input  logic               rsp_match_mark,
   input  logic               rsp_last_column,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 words_seen,
   output int                 columns_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import agga_pkg::*;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [23:0] score;
      logic [7:0]         ssym;
      logic [7:0]         tsym;
      logic               mark;
      logic               last;
   } column_word_type;

   column_word_type expected_words[$];

   longint open_pen, extend_pen, match_val, mismatch_val;
   logic [7:0] src_seq[MaxLen];
   logic [7:0] txt_seq[MaxLen];
   int src_len, txt_len, row_pos, col_pos;
   longint best[MaxLen + 1];
   longint vgap[MaxLen + 1];
   dir_type ptr[MaxLen + 1][MaxLen + 1];
   longint total_score;
   bit done_flag;

   function automatic longint clip(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic bit letter(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return l >= 8'h61 && l <= 8'h7a;
   endfunction

   function automatic void fill_matrix();
      longint neg, oe, diag, left, hrun, g, fu, fv, f, eu, ev, e, v;
      dir_type d;
      neg = clip(-4000000);
      oe = open_pen + extend_pen;
      best[0] = 0;
      for (int j = 1; j <= txt_len; j++) begin
         best[j] = clip(-open_pen - j * extend_pen);
         vgap[j] = neg;
      end
      for (int i = 1; i <= src_len; i++) begin
         diag = best[0];
         left = clip(-open_pen - i * extend_pen);
         best[0] = left;
         hrun = neg;
         for (int j = 1; j <= txt_len; j++) begin
            g = clip(diag + (((src_seq[i-1] & 8'hdf) == (txt_seq[j-1] & 8'hdf)) ?
                             match_val : mismatch_val));
            fu = clip(vgap[j] - extend_pen);
            fv = clip(best[j] - oe);
            f = fu > fv ? fu : fv;
            eu = clip(hrun - extend_pen);
            ev = clip(left - oe);
            e = eu > ev ? eu : ev;
            if (g >= f) v = g >= e ? g : e;
            else v = f >= e ? f : e;
            if (v == f) d = DIR_UP;
            else if (v == e) d = DIR_LEFT;
            else d = DIR_DIAG;
            ptr[i][j] = d;
            diag = best[j];
            best[j] = v;
            vgap[j] = f;
            hrun = e;
            left = v;
         end
      end
      total_score = best[txt_len];
      row_pos = src_len;
      col_pos = txt_len;
      done_flag = 1;
   endfunction

   function automatic column_word_type serve(logic [2:0] kind, logic [7:0] sym);
      column_word_type w;
      dir_type d;
      w = '0;
      case (kind) inside
         REQ_CLEAR: begin
            src_len = 0; txt_len = 0; done_flag = 0; total_score = 0;
            row_pos = 0; col_pos = 0;
         end
         REQ_SRC, REQ_TXT: begin
            if (!letter(sym)) w.status = ST_NONLETTER;
            else if ((kind == REQ_SRC ? src_len : txt_len) >= MaxLen) w.status = ST_FULL;
            else begin
               if (kind == REQ_SRC) begin src_seq[src_len] = sym; src_len++; end
               else begin txt_seq[txt_len] = sym; txt_len++; end
               done_flag = 0;
            end
         end
         REQ_COMPUTE: fill_matrix();
         REQ_NEXT: begin
            if (!done_flag) w.status = ST_NOT_COMPUTED;
            else if (row_pos == 0 && col_pos == 0) w.status = ST_FINISHED;
            else begin
               if (row_pos == 0) d = DIR_LEFT;
               else if (col_pos == 0) d = DIR_UP;
               else d = ptr[row_pos][col_pos];
               if (d == DIR_DIAG) begin
                  w.ssym = src_seq[row_pos-1]; w.tsym = txt_seq[col_pos-1];
                  row_pos--; col_pos--;
               end else if (d == DIR_UP) begin
                  w.ssym = src_seq[row_pos-1]; w.tsym = GapChar; row_pos--;
               end else begin
                  w.ssym = GapChar; w.tsym = txt_seq[col_pos-1]; col_pos--;
               end
               w.mark = w.ssym == w.tsym;
               w.last = row_pos == 0 && col_pos == 0;
            end
         end
         default: ;
      endcase
      w.score = done_flag ? 24'(total_score) : '0;
      return w;
   endfunction

   always @(posedge clock) begin
      column_word_type got, want;
      if (reset) begin
         open_pen = 0; extend_pen = 0; match_val = 20; mismatch_val = -4;
         src_len = 0; txt_len = 0; total_score = 0; row_pos = 0; col_pos = 0;
         done_flag = 0;
         expected_words.delete();
         fail_count <= 0;
         pending <= 0;
         words_seen <= 0;
         columns_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OPEN: open_pen = csr_data;
               CSR_EXTEND: extend_pen = csr_data;
               CSR_MATCH: match_val = $signed(csr_data);
               default: mismatch_val = $signed(csr_data);
            endcase
         end
         if (req_valid && req_ready) expected_words.push_back(serve(req_type, req_symbol));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_score, rsp_source_symbol, rsp_text_symbol,
                   rsp_match_mark, rsp_last_column};
            words_seen <= words_seen + 1;
            if (rsp_source_symbol != 0) columns_seen <= columns_seen + 1;
            if (expected_words.size() == 0) begin
               $display("%t: unexpected word %h", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  $display("%t: mismatch expected st=%0d sc=%0d s=%h t=%h m=%b l=%b",
                           $realtime, want.status, want.score, want.ssym, want.tsym,
                           want.mark, want.last);
                  $display("%t:          actual   st=%0d sc=%0d s=%h t=%h m=%b l=%b",
                           $realtime, got.status, got.score, got.ssym, got.tsym,
                           got.mark, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_words.size();
      end
   end
endmodule

// ----- test/affine_gap_global_alignment_unit_test.sv -----
module affine_gap_global_alignment_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import agga_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic [2:0] req_type = '0;
   logic [7:0] req_symbol = '0;
   logic rsp_valid, rsp_ready = 0;
   logic [2:0] rsp_status;
   logic signed [23:0] rsp_score;
   logic [7:0] rsp_source_symbol, rsp_text_symbol;
   logic rsp_match_mark, rsp_last_column;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = '0;
   logic [9:0] csr_data = '0;
   int fail_count, pending, words_seen, columns_seen;
   int stall_left = 0;
   bit hold_rsp = 0;

   always #5 clock = ~clock;

   affine_gap_global_alignment_unit dut (.*);
   affine_gap_global_alignment_unit_checker checker_u (.*);

   initial begin
      #40ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 0;
         stall_left <= gap_len();
      end else rsp_ready <= 1;
   end

   task automatic send(req_code_type kind, logic [7:0] sym, bit gaps = 1);
      int g;
      g = gaps ? gap_len() : 0;
      // the block is not ready again straight after an accepted word
      repeat (g + 1) @(posedge clock);
      req_valid <= 1;
      req_type <= kind;
      req_symbol <= sym;
      do @(posedge clock); while (!(req_valid && req_ready));
      req_valid <= 0;
   endtask

   task automatic drain();
      while (pending != 0 || req_valid) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [9:0] value);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_letter(int alpha);
      logic [7:0] c;
      c = 8'h41 + 8'($urandom_range(0, alpha - 1));
      if ($urandom_range(0, 1)) c = c | 8'h20;
      return c;
   endfunction

   task automatic one_alignment(int ls, int lt, int alpha);
      send(REQ_CLEAR, 8'($urandom()));
      for (int i = 0; i < ls; i++) send(REQ_SRC, rand_letter(alpha));
      for (int i = 0; i < lt; i++) send(REQ_TXT, rand_letter(alpha));
      if ($urandom_range(0, 4) == 0) send(REQ_TXT, 8'($urandom_range(0, 64)));
      send(REQ_COMPUTE, 8'($urandom()));
      for (int i = 0; i < ls + lt + 2; i++) send(REQ_NEXT, 8'($urandom()));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: before compute, empty sequences, non-letters, odd codes
      send(REQ_NEXT, 8'h00);
      send(REQ_COMPUTE, 8'hff);
      send(REQ_NEXT, 8'h00);
      send(REQ_NEXT, 8'h00);
      send(REQ_SRC, 8'h00);
      send(REQ_TXT, 8'hff);
      send(REQ_SRC, 8'h5b);
      send(REQ_SRC, 8'h41);
      send(REQ_SRC, 8'h7a);
      send(REQ_TXT, 8'h61);
      send(REQ_TXT, 8'h5a);
      send(REQ_COMPUTE, 8'h00);
      send(REQ_NEXT, 8'h00);
      send(REQ_TXT, 8'h62);
      send(REQ_NEXT, 8'h00);
      send(REQ_COMPUTE, 8'h00);
      repeat (5) send(REQ_NEXT, 8'h00);
      send(req_code_type'(3'd5), 8'h41);
      send(req_code_type'(3'd7), 8'hbe);
      send(REQ_CLEAR, 8'h00);

      // store full on both sequences, source only then text only edges
      for (int i = 0; i < 257; i++) send(REQ_SRC, rand_letter(26), 0);
      send(REQ_COMPUTE, 8'h00);
      send(REQ_NEXT, 8'h00); send(REQ_NEXT, 8'h00);
      send(REQ_CLEAR, 8'h00);
      for (int i = 0; i < 257; i++) send(REQ_TXT, rand_letter(26), 0);
      send(REQ_COMPUTE, 8'h00);
      send(REQ_NEXT, 8'h00);
      send(REQ_CLEAR, 8'h00);

      // settings swept across phases, extremes included
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_csr(CSR_OPEN, 10'd0); write_csr(CSR_EXTEND, 10'd0); end
            1: begin write_csr(CSR_OPEN, 10'd1023); write_csr(CSR_EXTEND, 10'd1023);
                     write_csr(CSR_MATCH, 10'h1ff); write_csr(CSR_MISMATCH, 10'h200); end
            2: begin write_csr(CSR_OPEN, 10'd40); write_csr(CSR_EXTEND, 10'd4);
                     write_csr(CSR_MATCH, 10'd20); write_csr(CSR_MISMATCH, -10'sd4); end
            3: begin write_csr(CSR_MATCH, 10'h200); write_csr(CSR_MISMATCH, 10'h1ff); end
            default: begin
               write_csr(CSR_OPEN, 10'($urandom())); write_csr(CSR_EXTEND, 10'($urandom()));
               write_csr(CSR_MATCH, 10'($urandom()));
               write_csr(CSR_MISMATCH, 10'($urandom()));
            end
         endcase
         for (int k = 0; k < 6; k++) begin
            int ls, lt;
            ls = $urandom_range(0, 8);
            lt = $urandom_range(0, 8);
            if (k == 3) begin hold_rsp = 1; drain(); hold_rsp = 0; end
            if ($urandom_range(0, 6) == 0)
               send(req_code_type'(3'($urandom_range(0, 7))), 8'($urandom()));
            one_alignment(ls, lt, $urandom_range(0, 1) ? 2 : 26);
         end
      end

      drain();
      $display("%0d words checked, %0d alignment columns traced over 8 settings",
               words_seen, columns_seen);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

// ----- files.f -----
design/agga_pkg.sv
design/agga_cell.sv
design/affine_gap_global_alignment_unit.sv
design/agga_checker.sv
test/affine_gap_global_alignment_unit_checker.sv
test/affine_gap_global_alignment_unit_test.sv
